// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and muted during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/gcmd_pkg.sv =====
// ---------------------------------------------------------------------------
// Great-circle minimum distance package
// Beat payload types, sequencer states and fixed-point constants.
// ---------------------------------------------------------------------------
package gcmd_pkg;

	localparam int ITERS = 30;

	localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;
	localparam logic signed [33:0] HALF_TURN = 34'sd2147483648;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [32:0] PI_Q30   = 33'sd3373259426;
	localparam logic [31:0]        RADIUS_RESET = 32'd6372798;

	// Arctangent of 2^-i as a binary angle (2^31 is a half turn).
	localparam logic [29:0] ATAN_BA [ITERS] = '{
		30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
		30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E,
		30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2F9,
		30'h0000517C, 30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
		30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051, 30'h00000028,
		30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
	};

	typedef struct packed {
		logic signed [31:0] first_latitude;
		logic signed [31:0] first_longitude;
		logic signed [31:0] second_latitude;
		logic signed [31:0] second_longitude;
		logic               group_end;
	} gcmd_in_t;

	typedef struct packed {
		logic [33:0] pair_distance;
		logic [33:0] group_minimum;
		logic        minimum_final;
	} gcmd_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROT,
		ST_COSEND,
		ST_MUL_CC,
		ST_MUL_VP,
		ST_HALF,
		ST_SQRT,
		ST_VLOAD,
		ST_VEC,
		ST_ZEND,
		ST_MUL_PI,
		ST_MUL_R,
		ST_OUT
	} gcmd_state_t;

endpackage

// ===== sv/gcmd_ifs.sv =====
// ---------------------------------------------------------------------------
// Great-circle minimum distance channels
// Valid/ready channels for point-pair beats and distance beats.
// ---------------------------------------------------------------------------
interface gcmd_in_if import gcmd_pkg::*; ();
	logic     valid;
	logic     ready;
	gcmd_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface gcmd_out_if import gcmd_pkg::*; ();
	logic      valid;
	logic      ready;
	gcmd_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/great_circle_min_distance_top.sv =====
// One pair is worked at a time. A haversine term that clamps to zero or one skips
// the square root and the arcsine. The next pair is taken in the cycle after a result
// loads, and a stalled output beat holds the sequencer until the result can load.
// One shared CORDIC unit works four cosines and one arcsine (one rotation per cycle),
// and two square roots are worked side by side, each retiring two radicand bits per cycle.
// arst_n clears the sequencer, the running minimum and the output beat, and loads
// the radius register with its default of 6372798 metres.
// ---------------------------------------------------------------------------
// Great-circle minimum distance
// Haversine distance of each point pair and running minimum over a group.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module great_circle_min_distance_top import gcmd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	gcmd_in_if.sink     in_ch,
	gcmd_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	gcmd_state_t state_q, state_d;

	logic [31:0]        radius_q;
	logic signed [31:0] ang_q [4];
	logic signed [31:0] cos_q [4];
	logic [1:0]         idx_q;
	logic               last_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0]         step_q;
	logic               neg_q;
	logic               vec_q;
	logic [59:0]        sqx_n_q, sqy_n_q;
	logic [30:0]        sqx_rem_q, sqy_rem_q;
	logic [29:0]        sqx_root_q, sqy_root_q;
	logic [30:0]        zf_q;
	logic signed [65:0] prod_q;
	logic [33:0]        rm_q;
	logic               mv_q;
	logic               out_valid_q;
	gcmd_out_t          out_q;

	logic in_fire, out_load, last_step;

	// CORDIC step
	logic signed [33:0] dx, dy, at, nx, ny, nz;
	logic               pos;

	// Angle folding into [-90, 90] degrees
	logic signed [33:0] t_ext, t_fold;
	logic               t_neg;
	logic signed [33:0] cclamp, cres;

	// Multiplier
	logic signed [32:0] mul_a, mul_b;

	// Haversine term
	logic signed [33:0] u_val, vp_val, h_sum, h_val, one_m_h;

	// Square root steps
	logic [32:0] sqx_rem2, sqy_rem2, sqx_trial, sqy_trial;

	// Result
	logic [63:0] dist_sum;
	logic [33:0] dist_m, new_min;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign last_step = (step_q == 5'(ITERS - 1));

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	always_comb begin
		dx  = cy_q >>> step_q;
		dy  = cx_q >>> step_q;
		at  = signed'({4'b0000, ATAN_BA[step_q]});
		pos = vec_q ? cy_q[33] : !cz_q[33];
		nx  = pos ? cx_q - dx : cx_q + dx;
		ny  = pos ? cy_q + dy : cy_q - dy;
		nz  = pos ? cz_q - at : cz_q + at;
	end

	always_comb begin
		t_ext = {{2{ang_q[idx_q][31]}}, ang_q[idx_q]};
		t_neg = 1'b0;
		t_fold = t_ext;
		if (t_ext > ONE_Q30) begin
			t_fold = t_ext - HALF_TURN;
			t_neg  = 1'b1;
		end else if (t_ext < -ONE_Q30) begin
			t_fold = t_ext + HALF_TURN;
			t_neg  = 1'b1;
		end
		if (cx_q > ONE_Q30) begin
			cclamp = ONE_Q30;
		end else if (cx_q < -ONE_Q30) begin
			cclamp = -ONE_Q30;
		end else begin
			cclamp = cx_q;
		end
		cres = neg_q ? -cclamp : cclamp;
	end

	always_comb begin
		u_val   = ONE_Q30 - {{2{cos_q[0][31]}}, cos_q[0]};
		vp_val  = prod_q[63:30];
		h_sum   = u_val + vp_val;
		h_val   = h_sum >>> 1;
		one_m_h = ONE_Q30 - h_val;
	end

	always_comb begin
		sqx_rem2  = {sqx_rem_q, sqx_n_q[59:58]};
		sqy_rem2  = {sqy_rem_q, sqy_n_q[59:58]};
		sqx_trial = {1'b0, sqx_root_q, 2'b01};
		sqy_trial = {1'b0, sqy_root_q, 2'b01};
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_CC: begin
				mul_a = {cos_q[2][31], cos_q[2]};
				mul_b = {cos_q[3][31], cos_q[3]};
			end
			ST_MUL_VP: begin
				mul_a = 33'(ONE_Q30 - {{2{cos_q[1][31]}}, cos_q[1]});
				mul_b = prod_q[62:30];
			end
			ST_MUL_PI: begin
				mul_a = {2'b00, zf_q};
				mul_b = PI_Q30;
			end
			ST_MUL_R: begin
				mul_a = {1'b0, radius_q};
				mul_b = {1'b0, prod_q[61:30]};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		// The rounding add wraps at 64 bits, which the distance field absorbs.
		dist_sum = 64'(prod_q[63:0]) + 64'd536870912;
		dist_m   = dist_sum[63:30];
		new_min  = (!mv_q || dist_m < rm_q) ? dist_m : rm_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_fire) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_ROT;
			ST_ROT:    if (last_step) state_d = ST_COSEND;
			ST_COSEND: state_d = (idx_q == 2'd3) ? ST_MUL_CC : ST_LOAD;
			ST_MUL_CC: state_d = ST_MUL_VP;
			ST_MUL_VP: state_d = ST_HALF;
			ST_HALF: begin
				if (h_val >= ONE_Q30 || h_val <= 34'sd0) begin
					state_d = ST_MUL_PI;
				end else begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT:   if (last_step) state_d = ST_VLOAD;
			ST_VLOAD:  state_d = ST_VEC;
			ST_VEC:    if (last_step) state_d = ST_ZEND;
			ST_ZEND:   state_d = ST_MUL_PI;
			ST_MUL_PI: state_d = ST_MUL_R;
			ST_MUL_R:  state_d = ST_OUT;
			ST_OUT:    if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RESET;
			rm_q        <= '0;
			mv_q        <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			idx_q       <= '0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (last_q) begin
					rm_q <= '0;
					mv_q <= 1'b0;
				end else begin
					rm_q <= new_min;
					mv_q <= 1'b1;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
			end else if (state_q == ST_COSEND) begin
				idx_q <= idx_q + 2'd1;
			end
			if (state_q == ST_ROT || state_q == ST_SQRT || state_q == ST_VEC) begin
				step_q <= last_step ? 5'd0 : step_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pair_distance <= dist_m;
			out_q.group_minimum <= new_min;
			out_q.minimum_final <= last_q;
		end
		if (state_q == ST_MUL_CC || state_q == ST_MUL_VP || state_q == ST_MUL_PI
				|| state_q == ST_MUL_R) begin
			prod_q <= 66'(mul_a) * 66'(mul_b);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					ang_q[0] <= in_ch.data.first_latitude - in_ch.data.second_latitude;
					ang_q[1] <= in_ch.data.first_longitude - in_ch.data.second_longitude;
					ang_q[2] <= in_ch.data.first_latitude;
					ang_q[3] <= in_ch.data.second_latitude;
					last_q   <= in_ch.data.group_end;
				end
			end
			ST_LOAD: begin
				cx_q  <= GAIN_Q30;
				cy_q  <= '0;
				cz_q  <= t_fold;
				neg_q <= t_neg;
				vec_q <= 1'b0;
			end
			ST_ROT, ST_VEC: begin
				cx_q <= nx;
				cy_q <= ny;
				cz_q <= nz;
			end
			ST_COSEND: begin
				cos_q[idx_q] <= cres[31:0];
			end
			ST_HALF: begin
				if (h_val >= ONE_Q30) begin
					zf_q <= 31'd1073741824;
				end else if (h_val <= 34'sd0) begin
					zf_q <= '0;
				end
				sqx_n_q    <= {one_m_h[29:0], 30'd0};
				sqy_n_q    <= {h_val[29:0], 30'd0};
				sqx_rem_q  <= '0;
				sqy_rem_q  <= '0;
				sqx_root_q <= '0;
				sqy_root_q <= '0;
			end
			ST_SQRT: begin
				// Restoring square root: two radicand bits per cycle, one root bit.
				sqx_n_q <= {sqx_n_q[57:0], 2'b00};
				sqy_n_q <= {sqy_n_q[57:0], 2'b00};
				if (sqx_rem2 >= sqx_trial) begin
					sqx_rem_q  <= 31'(sqx_rem2 - sqx_trial);
					sqx_root_q <= {sqx_root_q[28:0], 1'b1};
				end else begin
					sqx_rem_q  <= sqx_rem2[30:0];
					sqx_root_q <= {sqx_root_q[28:0], 1'b0};
				end
				if (sqy_rem2 >= sqy_trial) begin
					sqy_rem_q  <= 31'(sqy_rem2 - sqy_trial);
					sqy_root_q <= {sqy_root_q[28:0], 1'b1};
				end else begin
					sqy_rem_q  <= sqy_rem2[30:0];
					sqy_root_q <= {sqy_root_q[28:0], 1'b0};
				end
			end
			ST_VLOAD: begin
				cx_q  <= {4'b0000, sqx_root_q};
				cy_q  <= {4'b0000, sqy_root_q};
				cz_q  <= '0;
				vec_q <= 1'b1;
			end
			ST_ZEND: begin
				if (cz_q < 34'sd0) begin
					zf_q <= '0;
				end else if (cz_q > ONE_Q30) begin
					zf_q <= 31'd1073741824;
				end else begin
					zf_q <= cz_q[30:0];
				end
			end
			default: begin
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_starts, in_fire, state_q == ST_LOAD, "accepted beat did not start work")
	`ASSERT_ALWAYS(a_min_cleared, mv_q || rm_q == 34'd0, "running minimum set while invalid")
	`ASSERT_IMPL(a_min_bound, out_valid_q, out_q.group_minimum <= out_q.pair_distance, "minimum above distance")
	`ASSERT_ALWAYS(a_step_range, step_q <= 5'(ITERS - 1), "step counter out of range")

endmodule
